// ===== src/kt_pkg.sv =====
// Shared types and constants for the keyed table.
package kt_pkg;

  localparam int unsigned KeyBits      = 32;
  localparam int unsigned ValueInBits  = 32;
  localparam int unsigned CountOutBits = 6;
  localparam int unsigned ModeBits     = 2;
  localparam int unsigned StatusBits   = 2;

  localparam int unsigned DefDepth     = 32;
  localparam int unsigned DefValueBits = 32;

  typedef enum logic [ModeBits-1:0] {
    ModeInsert = 2'd0,
    ModeErase  = 2'd1,
    ModeQuery  = 2'd2
  } kt_mode_e;

  typedef enum logic [StatusBits-1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusFull     = 2'd2,
    StatusDup      = 2'd3
  } kt_status_e;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StSwapRd,
    StSwapWr,
    StResp
  } kt_state_e;

endpackage

// ===== src/kt_req_if.sv =====
// Request channel: mode, key and value with valid/ready.
interface kt_req_if;
  logic                               valid;
  logic                               ready;
  logic [kt_pkg::ModeBits-1:0]        mode;
  logic signed [kt_pkg::KeyBits-1:0]  key;
  logic [kt_pkg::ValueInBits-1:0]     value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

// ===== src/kt_rsp_if.sv =====
// Response channel: status, found flag and entry count with valid/ready.
interface kt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [kt_pkg::StatusBits-1:0]     status;
  logic                              found;
  logic [kt_pkg::CountOutBits-1:0]   count;

  modport source (output valid, status, found, count, input ready);
  modport sink   (input valid, status, found, count, output ready);
endinterface

// ===== src/keyed_table_insert_erase_lookup.sv =====
// Top level of the keyed table: request/response channels around the sequencer and entry RAM.
//
// An unordered table of up to DEPTH key/value entries held in one RAM with registered read.
// Each request inserts, erases or looks up a key; every request yields exactly one response
// with status, a found flag and the entry count afterwards. The time from acceptance to a loaded
// response grows with the entry count when the key is absent, is shorter when the key is found
// early, and is longer for an erase that moves the last entry into the freed slot through the swap
// read and swap write states. It is set by the linear search, which reads one RAM entry per cycle
// through the single read port. The request channel is ready again in the cycle after the response
// is loaded into the output register, even while that response waits to be taken.
module keyed_table_insert_erase_lookup #(
  parameter int unsigned DEPTH      = kt_pkg::DefDepth,
  parameter int unsigned VALUE_BITS = kt_pkg::DefValueBits
) (
  input logic     clk_i,
  input logic     rst_ni,
  kt_req_if.sink  req_i,
  kt_rsp_if.source rsp_o
);

  localparam int unsigned AddrW  = $clog2(DEPTH);
  localparam int unsigned EntryW = kt_pkg::KeyBits + VALUE_BITS;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [EntryW-1:0]     ram_wdata;
  logic [AddrW-1:0]      ram_raddr;
  logic [EntryW-1:0]     ram_rdata;
  logic [VALUE_BITS-1:0] req_value;

  assign req_value = VALUE_BITS'({{VALUE_BITS{1'b0}}, req_i.value});

  kt_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_mode_i   (req_i.mode),
    .req_key_i    (req_i.key),
    .req_value_i  (req_value),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_found_o  (rsp_o.found),
    .rsp_count_o  (rsp_o.count),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  kt_ram #(
    .Width (EntryW),
    .Depth (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== src/kt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module kt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/kt_ctrl.sv =====
// Sequencer: linear search over the entry RAM, insert, swap-remove and response register.
module kt_ctrl #(
  parameter int unsigned DEPTH      = kt_pkg::DefDepth,
  parameter int unsigned VALUE_BITS = kt_pkg::DefValueBits,
  localparam int unsigned AddrW     = $clog2(DEPTH),
  localparam int unsigned CntW      = $clog2(DEPTH + 1),
  localparam int unsigned EntryW    = kt_pkg::KeyBits + VALUE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  logic [kt_pkg::ModeBits-1:0]     req_mode_i,
  input  logic [kt_pkg::KeyBits-1:0]      req_key_i,
  input  logic [VALUE_BITS-1:0]           req_value_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output logic [kt_pkg::StatusBits-1:0]   rsp_status_o,
  output logic                            rsp_found_o,
  output logic [kt_pkg::CountOutBits-1:0] rsp_count_o,
  output logic                            ram_we_o,
  output logic [AddrW-1:0]                ram_waddr_o,
  output logic [EntryW-1:0]               ram_wdata_o,
  output logic [AddrW-1:0]                ram_raddr_o,
  input  logic [EntryW-1:0]               ram_rdata_i
);

  kt_pkg::kt_state_e state_q, state_d;

  logic [kt_pkg::ModeBits-1:0]   mode_q;
  logic [kt_pkg::KeyBits-1:0]    key_q;
  logic [VALUE_BITS-1:0]         value_q;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [CntW-1:0]               idx_q, idx_d;
  logic                          pend_q, pend_d;
  logic [AddrW-1:0]              pidx_q, pidx_d;
  logic [AddrW-1:0]              slot_q, slot_d;
  logic [kt_pkg::StatusBits-1:0] status_q, status_d;
  logic                          found_q, found_d;
  logic                          rsp_valid_q, rsp_valid_d;
  logic [kt_pkg::StatusBits-1:0] rsp_status_q, rsp_status_d;
  logic                          rsp_found_q, rsp_found_d;
  logic [CntW-1:0]               rsp_cnt_q, rsp_cnt_d;

  logic                          accept;
  logic                          issue;
  logic                          hit;
  logic                          decide;
  logic                          full;
  logic                          rsp_load;
  logic [kt_pkg::KeyBits-1:0]    rd_key;
  logic [CntW-1:0]               last_cnt;

  assign accept   = req_valid_i && req_ready_o;
  assign issue    = (state_q == kt_pkg::StSearch) && (idx_q < cnt_q);
  assign rd_key   = ram_rdata_i[EntryW-1 -: kt_pkg::KeyBits];
  assign hit      = pend_q && (rd_key == key_q);
  assign decide   = (state_q == kt_pkg::StSearch) && (hit || (!issue && !pend_q));
  assign full     = (cnt_q == CntW'(DEPTH));
  assign rsp_load = (state_q == kt_pkg::StResp) && (!rsp_valid_q || rsp_ready_i);
  assign last_cnt = cnt_q - CntW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kt_pkg::StIdle: begin
        if (accept) state_d = kt_pkg::StSearch;
      end
      kt_pkg::StSearch: begin
        if (decide) begin
          if ((mode_q == kt_pkg::ModeErase) && hit) state_d = kt_pkg::StSwapRd;
          else state_d = kt_pkg::StResp;
        end
      end
      kt_pkg::StSwapRd: state_d = kt_pkg::StSwapWr;
      kt_pkg::StSwapWr: state_d = kt_pkg::StResp;
      kt_pkg::StResp: begin
        if (rsp_load) state_d = kt_pkg::StIdle;
      end
      default: state_d = kt_pkg::StIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_ready_o  = (state_q == kt_pkg::StIdle);
    ram_we_o     = 1'b0;
    ram_waddr_o  = cnt_q[AddrW-1:0];
    ram_wdata_o  = {key_q, value_q};
    ram_raddr_o  = idx_q[AddrW-1:0];
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pend_d       = issue;
    pidx_d       = idx_q[AddrW-1:0];
    slot_d       = slot_q;
    status_d     = status_q;
    found_d      = found_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    rsp_status_d = rsp_status_q;
    rsp_found_d  = rsp_found_q;
    rsp_cnt_d    = rsp_cnt_q;

    if (accept) begin
      idx_d = '0;
    end
    if (issue) begin
      idx_d = idx_q + CntW'(1);
    end

    if (decide) begin
      found_d = hit;
      slot_d  = pidx_q;
      unique case (mode_q)
        kt_pkg::ModeInsert: begin
          if (full) begin
            status_d = kt_pkg::StatusFull;
          end else if (hit) begin
            status_d = kt_pkg::StatusDup;
          end else begin
            status_d = kt_pkg::StatusOk;
            ram_we_o = 1'b1;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        kt_pkg::ModeErase: begin
          status_d = hit ? kt_pkg::StatusOk : kt_pkg::StatusNotFound;
        end
        default: begin
          status_d = hit ? kt_pkg::StatusOk : kt_pkg::StatusNotFound;
        end
      endcase
    end

    if (state_q == kt_pkg::StSwapRd) begin
      ram_raddr_o = last_cnt[AddrW-1:0];
    end

    if (state_q == kt_pkg::StSwapWr) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = slot_q;
      ram_wdata_o = ram_rdata_i;
      cnt_d       = last_cnt;
    end

    if (rsp_load) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = status_q;
      rsp_found_d  = found_q;
      rsp_cnt_d    = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kt_pkg::StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= req_mode_i;
      key_q   <= req_key_i;
      value_q <= req_value_i;
    end
    pidx_q       <= pidx_d;
    slot_q       <= slot_d;
    status_q     <= status_d;
    found_q      <= found_d;
    rsp_status_q <= rsp_status_d;
    rsp_found_q  <= rsp_found_d;
    rsp_cnt_q    <= rsp_cnt_d;
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_found_o  = rsp_found_q;
  assign rsp_count_o  = kt_pkg::CountOutBits'({{kt_pkg::CountOutBits{1'b0}}, rsp_cnt_q});

endmodule

// ===== test/keyed_table_insert_erase_lookup_tb.sv =====
// Self-checking testbench for the keyed table: predicted responses, random flow control.
module keyed_table_insert_erase_lookup_tb;

  localparam int unsigned DEPTH     = kt_pkg::DefDepth;
  localparam int unsigned KEY_POOL  = 44;
  localparam int unsigned RAND_REQS = 1800;
  localparam int unsigned LIMIT     = 1000000;
  localparam logic [kt_pkg::ModeBits-1:0] ModeSpare = 2'd3;

  typedef struct packed {
    logic [kt_pkg::ModeBits-1:0]       mode;
    logic signed [kt_pkg::KeyBits-1:0] key;
    logic [kt_pkg::ValueInBits-1:0]    value;
  } table_req_t;

  typedef struct packed {
    kt_pkg::kt_status_e              status;
    logic                            found;
    logic [kt_pkg::CountOutBits-1:0] count;
  } table_rsp_t;

  logic clk_i;
  logic rst_ni;

  kt_req_if req_if ();
  kt_rsp_if rsp_if ();

  keyed_table_insert_erase_lookup #(
    .DEPTH     (DEPTH),
    .VALUE_BITS(kt_pkg::DefValueBits)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  table_req_t pending_reqs[$];
  table_rsp_t expected_rsps[$];

  logic [kt_pkg::KeyBits-1:0]     shadow_key[DEPTH];
  logic [kt_pkg::ValueInBits-1:0] shadow_val[DEPTH];
  int unsigned                    shadow_cnt;

  logic signed [kt_pkg::KeyBits-1:0] key_pool[KEY_POOL];

  int unsigned cycles;
  int unsigned errors;
  int unsigned rsp_seen;
  int unsigned full_seen;
  int unsigned dup_seen;
  int unsigned miss_seen;
  int unsigned peak_cnt;
  int unsigned taken_cnt;
  int unsigned sent_cnt;
  int unsigned burst_left;
  int unsigned idle_left;
  logic [31:0] stall_pat;
  int unsigned stall_kind;
  int unsigned stall_ph;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic table_rsp_t apply_request(table_req_t r);
    table_rsp_t  rsp;
    int unsigned slot;
    bit          present;
    slot    = shadow_cnt;
    present = 1'b0;
    for (int unsigned i = 0; i < shadow_cnt; i++) begin
      if (!present && shadow_key[i] == r.key) begin
        slot    = i;
        present = 1'b1;
      end
    end
    rsp.status = kt_pkg::StatusOk;
    case (r.mode)
      kt_pkg::ModeInsert: begin
        if (shadow_cnt >= DEPTH) begin
          rsp.status = kt_pkg::StatusFull;
        end else if (present) begin
          rsp.status = kt_pkg::StatusDup;
        end else begin
          shadow_key[shadow_cnt] = r.key;
          shadow_val[shadow_cnt] = r.value;
          shadow_cnt++;
        end
      end
      kt_pkg::ModeErase: begin
        if (!present) begin
          rsp.status = kt_pkg::StatusNotFound;
        end else begin
          shadow_cnt--;
          shadow_key[slot] = shadow_key[shadow_cnt];
          shadow_val[slot] = shadow_val[shadow_cnt];
        end
      end
      default: begin
        rsp.status = present ? kt_pkg::StatusOk : kt_pkg::StatusNotFound;
      end
    endcase
    rsp.found = present;
    rsp.count = shadow_cnt[kt_pkg::CountOutBits-1:0];
    return rsp;
  endfunction

  function automatic void add_req(logic [kt_pkg::ModeBits-1:0] mode,
                                  logic [kt_pkg::KeyBits-1:0] key,
                                  logic [kt_pkg::ValueInBits-1:0] value);
    table_req_t r;
    r.mode  = mode;
    r.key   = key;
    r.value = value;
    pending_reqs.push_back(r);
  endfunction

  // request acceptance and prediction
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_rsps.push_back(apply_request(pending_reqs[0]));
      pending_reqs.pop_front();
      taken_cnt++;
    end
  end

  // request driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || taken_cnt == sent_cnt)) begin
      if (idle_left > 0) begin
        req_if.valid <= 1'b0;
        idle_left--;
      end else if (pending_reqs.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.mode  <= pending_reqs[0].mode;
        req_if.key   <= pending_reqs[0].key;
        req_if.value <= pending_reqs[0].value;
        sent_cnt++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response stall pattern
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cycles % 64 == 0) begin
        stall_kind = $urandom_range(0, 3);
        case (stall_kind)
          0:       stall_pat = '1;
          1:       stall_pat = $urandom();
          2:       stall_pat = $urandom() & $urandom();
          default: stall_pat = $urandom() | $urandom();
        endcase
      end
      rsp_if.ready <= stall_pat[stall_ph];
      stall_ph = (stall_ph + 1) % 32;
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    table_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected response status=%0d found=%0d count=%0d", $time,
                 rsp_if.status, rsp_if.found, rsp_if.count);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        rsp_seen++;
        if (exp_rsp.status == kt_pkg::StatusFull) full_seen++;
        if (exp_rsp.status == kt_pkg::StatusDup) dup_seen++;
        if (exp_rsp.status == kt_pkg::StatusNotFound) miss_seen++;
        if (exp_rsp.count > peak_cnt) peak_cnt = exp_rsp.count;
        if (rsp_if.status !== exp_rsp.status || rsp_if.found !== exp_rsp.found ||
            rsp_if.count !== exp_rsp.count) begin
          errors++;
          $display("%0t: expected status/found/count %0d/%0d/%0d, actual %0d/%0d/%0d",
                   $time, exp_rsp.status, exp_rsp.found, exp_rsp.count,
                   rsp_if.status, rsp_if.found, rsp_if.count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout, %0d requests and %0d responses outstanding", $time,
               pending_reqs.size(), expected_rsps.size());
      $display("** keyed_table_insert_erase_lookup: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned phase;
    int unsigned len;
    int unsigned pick;
    logic [kt_pkg::ModeBits-1:0] mode;
    logic [kt_pkg::KeyBits-1:0]  key;

    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode  = '0;
    req_if.key   = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    cycles       = 0;
    errors       = 0;
    rsp_seen     = 0;
    full_seen    = 0;
    dup_seen     = 0;
    miss_seen    = 0;
    peak_cnt     = 0;
    taken_cnt    = 0;
    sent_cnt     = 0;
    burst_left   = 1;
    idle_left    = 0;
    stall_pat    = '1;
    stall_kind   = 0;
    stall_ph     = 0;
    shadow_cnt   = 0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int unsigned i = 4; i < KEY_POOL; i++) begin
      key_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(1, 64);
    end

    // directed: extremes, duplicates, swap on erase, spare mode, empty table
    add_req(kt_pkg::ModeInsert, 32'h8000_0000, 32'h0000_0000);
    add_req(kt_pkg::ModeInsert, 32'h7fff_ffff, 32'hffff_ffff);
    add_req(kt_pkg::ModeInsert, 32'h0000_0000, 32'h1234_5678);
    add_req(kt_pkg::ModeInsert, 32'hffff_ffff, 32'h8000_0001);
    add_req(kt_pkg::ModeInsert, 32'h7fff_ffff, 32'h0000_0001);
    add_req(kt_pkg::ModeQuery,  32'h8000_0000, 32'hffff_ffff);
    add_req(kt_pkg::ModeQuery,  32'h0000_0001, 32'h0000_0000);
    add_req(ModeSpare,          32'h0000_0000, 32'h0000_0000);
    add_req(ModeSpare,          32'h0000_0005, 32'hffff_ffff);
    add_req(kt_pkg::ModeErase,  32'h0000_3039, 32'h0000_0000);
    add_req(kt_pkg::ModeErase,  32'h8000_0000, 32'h0000_0000);
    add_req(kt_pkg::ModeQuery,  32'hffff_ffff, 32'h0000_0000);
    add_req(kt_pkg::ModeQuery,  32'h8000_0000, 32'h0000_0000);
    add_req(kt_pkg::ModeErase,  32'hffff_ffff, 32'h0000_0000);
    add_req(kt_pkg::ModeErase,  32'h0000_0000, 32'h0000_0000);
    add_req(kt_pkg::ModeErase,  32'h7fff_ffff, 32'h0000_0000);
    add_req(kt_pkg::ModeErase,  32'h7fff_ffff, 32'h0000_0000);
    add_req(kt_pkg::ModeQuery,  32'h0000_0000, 32'h0000_0000);
    add_req(kt_pkg::ModeInsert, 32'h5555_5555, 32'haaaa_aaaa);
    add_req(kt_pkg::ModeInsert, 32'haaaa_aaaa, 32'h5555_5555);
    add_req(kt_pkg::ModeErase,  32'haaaa_aaaa, 32'h0000_0000);

    // random: fill, drain and mixed phases over a key pool larger than the table
    n = 0;
    while (n < RAND_REQS) begin
      phase = $urandom_range(0, 2);
      len   = $urandom_range(30, 90);
      for (int unsigned j = 0; j < len; j++) begin
        pick = $urandom_range(0, 99);
        case (phase)
          0:       mode = (pick < 75) ? kt_pkg::ModeInsert :
                          (pick < 90) ? kt_pkg::ModeQuery :
                          (pick < 97) ? kt_pkg::ModeErase : ModeSpare;
          1:       mode = (pick < 65) ? kt_pkg::ModeErase :
                          (pick < 80) ? kt_pkg::ModeInsert :
                          (pick < 95) ? kt_pkg::ModeQuery : ModeSpare;
          default: mode = (pick < 40) ? kt_pkg::ModeInsert :
                          (pick < 70) ? kt_pkg::ModeQuery :
                          (pick < 95) ? kt_pkg::ModeErase : ModeSpare;
        endcase
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                           : $urandom();
        add_req(mode, key, $urandom());
        n++;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (DEPTH + 16) @(posedge clk_i);

    $display("Checked %0d responses: %0d not found, %0d table full, %0d duplicate key,",
             rsp_seen, miss_seen, full_seen, dup_seen);
    $display("peak entry count %0d of %0d, %0d errors.", peak_cnt, DEPTH, errors);
    if (errors == 0) begin
      $display("** keyed_table_insert_erase_lookup: PASSED **");
    end else begin
      $display("** keyed_table_insert_erase_lookup: FAILED **");
    end
    $finish;
  end

endmodule
